FILE: hw/rtl/rv64_integer_subset_execute_unit_defines.svh
// Assertion macros for the RV64 integer subset execute unit checker.
// Needs clk and rst in the scope where a macro is used.
`ifndef RV64_INTEGER_SUBSET_EXECUTE_UNIT_DEFINES_SVH
`define RV64_INTEGER_SUBSET_EXECUTE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define RVX_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RVX_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/rvx_pkg.sv
// Shared types, codes and sizes for the RV64 integer subset execute unit.
// No dependencies; every other RTL module uses it.
`default_nettype none

package rvx_pkg;

  localparam int unsigned XLEN            = 64;
  localparam int unsigned ILEN            = 32;
  localparam int unsigned NUM_REGS        = 32;
  localparam int unsigned REG_ADDR_W      = 5;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [2:0] F3_ADDI = 3'd0;
  localparam logic [2:0] F3_SLLI = 3'd1;
  localparam logic [2:0] F3_ANDI = 3'd7;
  localparam logic [2:0] F3_WFI  = 3'd0;

  localparam logic [1:0] SZ_BYTE   = 2'd0;
  localparam logic [1:0] SZ_HALF   = 2'd1;
  localparam logic [1:0] SZ_WORD   = 2'd2;
  localparam logic [1:0] SZ_DOUBLE = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ILLEGAL = 2'd1;
  localparam logic [1:0] ST_UNIMPL  = 2'd2;

  typedef enum logic [3:0] {
    OP_AUIPC,
    OP_ADDI,
    OP_ANDI,
    OP_SLLI,
    OP_JAL,
    OP_STORE,
    OP_WFI,
    OP_SYS_NOP,
    OP_ILLEGAL
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [REG_ADDR_W-1:0] rd;
    logic [REG_ADDR_W-1:0] rs1;
    logic [REG_ADDR_W-1:0] rs2;
    logic [1:0]            size;
    logic [XLEN-1:0]       imm;
    logic [XLEN-1:0]       link;
    logic [XLEN-1:0]       next_pc;
  } dec_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rvx_ram.sv
// Generic RAM: one write port, two registered read ports.
// Defaults from rvx_pkg.
`default_nettype none

module rvx_ram #(
  parameter int unsigned WIDTH = rvx_pkg::XLEN,
  parameter int unsigned DEPTH = rvx_pkg::NUM_REGS,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [WIDTH-1:0]  rdata_a,
  output logic [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rvx_front.sv
// Front end: takes an instruction request, decodes and classifies it,
// computes immediates and pc targets. Uses rvx_pkg.
`default_nettype none

module rvx_front (
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [rvx_pkg::ILEN-1:0]   instruction_word,
  input  logic [rvx_pkg::XLEN-1:0]   current_pc,
  input  logic                       full,
  output logic                       push,
  output rvx_pkg::dec_t              item
);
  import rvx_pkg::*;

  logic [6:0]      opc;
  logic [2:0]      f3;
  logic [XLEN-1:0] iimm;
  logic [XLEN-1:0] simm;
  logic [XLEN-1:0] uimm;
  logic [XLEN-1:0] jimm;
  logic            is_jal;
  logic            is_auipc;

  assign in_ready = !full;
  assign push     = in_valid && !full;

  assign opc  = instruction_word[6:0];
  assign f3   = instruction_word[14:12];
  assign iimm = {{52{instruction_word[31]}}, instruction_word[31:20]};
  assign simm = {{52{instruction_word[31]}}, instruction_word[31:25], instruction_word[11:7]};
  assign uimm = {{32{instruction_word[31]}}, instruction_word[31:12], 12'b0};
  assign jimm = {{43{instruction_word[31]}}, instruction_word[31], instruction_word[19:12],
                 instruction_word[20], instruction_word[30:21], 1'b0};

  assign is_jal   = (opc == OPC_JAL);
  assign is_auipc = (opc == OPC_AUIPC);

  always_comb begin
    item         = '0;
    item.rd      = instruction_word[11:7];
    item.rs1     = instruction_word[19:15];
    item.rs2     = instruction_word[24:20];
    item.size    = f3[1:0];
    item.imm     = iimm;
    item.next_pc = current_pc + (is_jal ? jimm : XLEN'(4));
    item.link    = current_pc + (is_auipc ? uimm : XLEN'(4));
    item.op      = OP_ILLEGAL;
    case (opc)
      OPC_AUIPC: begin
        item.op = OP_AUIPC;
      end
      OPC_JAL: begin
        item.op = OP_JAL;
      end
      OPC_OPIMM: begin
        case (f3)
          F3_ADDI: item.op = OP_ADDI;
          F3_ANDI: item.op = OP_ANDI;
          F3_SLLI: begin
            if (instruction_word[31:26] == 6'd0) begin
              item.op = OP_SLLI;
            end
          end
          default: item.op = OP_ILLEGAL;
        endcase
      end
      OPC_STORE: begin
        item.imm = simm;
        if (f3 inside {[3'd0:3'd3]}) begin
          item.op = OP_STORE;
        end
      end
      OPC_SYSTEM: begin
        item.op = (f3 == F3_WFI) ? OP_WFI : OP_SYS_NOP;
      end
      default: item.op = OP_ILLEGAL;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rvx_queue.sv
// Decoded-request queue between front and back end.
// Register-based circular buffer of rvx_pkg::dec_t.
`default_nettype none

module rvx_queue #(
  parameter int unsigned DEPTH = rvx_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rvx_pkg::dec_t item,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output rvx_pkg::dec_t head
);
  import rvx_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  dec_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rvx_back.sv
// Back end: register file read with forwarding, execute, writeback,
// halt flag and result register. Uses rvx_pkg and rvx_ram.
`default_nettype none

module rvx_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      head_valid,
  input  rvx_pkg::dec_t             head,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [rvx_pkg::XLEN-1:0]  next_pc,
  output logic                      store_request,
  output logic [rvx_pkg::XLEN-1:0]  store_address,
  output logic [rvx_pkg::XLEN-1:0]  store_data,
  output logic [1:0]                store_size,
  output logic                      halted,
  output logic [1:0]                status
);
  import rvx_pkg::*;

  dec_t                  ex;
  logic                  ex_valid;
  logic                  ex_fire;
  logic                  ex_load;
  logic [REG_ADDR_W-1:0] raddr_a;
  logic [REG_ADDR_W-1:0] raddr_b;
  logic [XLEN-1:0]       ram_a;
  logic [XLEN-1:0]       ram_b;
  logic [NUM_REGS-1:0]   reg_valid;
  logic                  wb_valid;
  logic [REG_ADDR_W-1:0] wb_addr;
  logic [XLEN-1:0]       wb_data;
  logic [XLEN-1:0]       op_a;
  logic [XLEN-1:0]       op_b;
  logic [XLEN-1:0]       sum;
  logic [XLEN-1:0]       rd_value;
  logic                  writes;
  logic                  wr_en;
  logic                  is_store;
  logic [XLEN-1:0]       sdata;
  logic [1:0]            st_code;
  logic                  halt_flag;
  logic                  halt_next;

  assign ex_fire = ex_valid && (!out_valid || out_ready);
  assign ex_load = head_valid && (!ex_valid || ex_fire);
  assign pop     = ex_load;

  assign raddr_a = ex_load ? head.rs1 : ex.rs1;
  assign raddr_b = ex_load ? head.rs2 : ex.rs2;

  rvx_ram #(
    .WIDTH (XLEN),
    .DEPTH (NUM_REGS)
  ) u_regfile (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (ex.rd),
    .wdata   (rd_value),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  always_comb begin
    if (wb_valid && (wb_addr == ex.rs1)) begin
      op_a = wb_data;
    end else begin
      op_a = reg_valid[ex.rs1] ? ram_a : '0;
    end
    if (wb_valid && (wb_addr == ex.rs2)) begin
      op_b = wb_data;
    end else begin
      op_b = reg_valid[ex.rs2] ? ram_b : '0;
    end
  end

  assign sum = op_a + ex.imm;

  always_comb begin
    case (ex.op)
      OP_ADDI: rd_value = sum;
      OP_ANDI: rd_value = op_a & ex.imm;
      OP_SLLI: rd_value = op_a << ex.imm[5:0];
      default: rd_value = ex.link;
    endcase
  end

  assign writes   = ex.op inside {OP_AUIPC, OP_ADDI, OP_ANDI, OP_SLLI, OP_JAL};
  assign wr_en    = ex_fire && writes && (ex.rd != '0);
  assign is_store = (ex.op == OP_STORE);

  always_comb begin
    case (ex.size)
      SZ_BYTE: sdata = {56'd0, op_b[7:0]};
      SZ_HALF: sdata = {48'd0, op_b[15:0]};
      SZ_WORD: sdata = {32'd0, op_b[31:0]};
      default: sdata = op_b;
    endcase
  end

  always_comb begin
    case (ex.op)
      OP_ILLEGAL: st_code = ST_ILLEGAL;
      OP_SYS_NOP: st_code = ST_UNIMPL;
      default:    st_code = ST_OK;
    endcase
  end

  assign halt_next = halt_flag || (ex.op == OP_WFI);

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid  <= 1'b0;
      out_valid <= 1'b0;
      halt_flag <= 1'b0;
      reg_valid <= '0;
      wb_valid  <= 1'b0;
    end else begin
      if (ex_load) begin
        ex_valid <= 1'b1;
      end else if (ex_fire) begin
        ex_valid <= 1'b0;
      end
      if (ex_fire) begin
        out_valid <= 1'b1;
        halt_flag <= halt_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (wr_en) begin
        reg_valid[ex.rd] <= 1'b1;
        wb_valid         <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ex_load) begin
      ex <= head;
    end
    if (wr_en) begin
      wb_addr <= ex.rd;
      wb_data <= rd_value;
    end
    if (ex_fire) begin
      next_pc       <= ex.next_pc;
      store_request <= is_store;
      store_address <= is_store ? sum : '0;
      store_data    <= is_store ? sdata : '0;
      store_size    <= is_store ? ex.size : SZ_BYTE;
      halted        <= halt_next;
      status        <= st_code;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rv64_integer_subset_execute_unit.sv
// Top level of the RV64 integer subset execute unit: front end, request
// queue and back end. Uses rvx_pkg, rvx_front, rvx_queue, rvx_back.
//
//   channel | signals                                   | dir
//   --------+-------------------------------------------+-----
//   in      | in_valid, in_ready, instruction_word,     | in
//           | current_pc                                |
//   out     | out_valid, out_ready, next_pc, store_*,   | out
//           | halted, status                            |
//
// One request per cycle sustained when nothing stalls; a result passes from the
// queue through the register file read into the execute stage, then from execute
// into the result register.
// Register file reads are registered; the last writeback is forwarded.
// rst is synchronous: queue, pipeline, halt flag and register valid bits clear.
// A stalled result holds in its register while the queue takes requests until full.
`default_nettype none

module rv64_integer_subset_execute_unit #(
  parameter int unsigned QUEUE_DEPTH = rvx_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [rvx_pkg::ILEN-1:0]  instruction_word,
  input  logic [rvx_pkg::XLEN-1:0]  current_pc,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [rvx_pkg::XLEN-1:0]  next_pc,
  output logic                      store_request,
  output logic [rvx_pkg::XLEN-1:0]  store_address,
  output logic [rvx_pkg::XLEN-1:0]  store_data,
  output logic [1:0]                store_size,
  output logic                      halted,
  output logic [1:0]                status
);
  import rvx_pkg::*;

  dec_t item;
  dec_t head;
  logic push;
  logic full;
  logic pop;
  logic head_valid;

  rvx_front u_front (
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .instruction_word (instruction_word),
    .current_pc       (current_pc),
    .full             (full),
    .push             (push),
    .item             (item)
  );

  rvx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .item       (item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  rvx_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .next_pc       (next_pc),
    .store_request (store_request),
    .store_address (store_address),
    .store_data    (store_data),
    .store_size    (store_size),
    .halted        (halted),
    .status        (status)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/rvx_checker.sv
// Port-level checks on the result channel of the execute unit, and the
// bind that attaches them. Uses rvx_pkg and the assertion macros header.
`default_nettype none
`include "rv64_integer_subset_execute_unit_defines.svh"

module rvx_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [rvx_pkg::XLEN-1:0]  next_pc,
  input logic                      store_request,
  input logic [rvx_pkg::XLEN-1:0]  store_address,
  input logic [rvx_pkg::XLEN-1:0]  store_data,
  input logic [1:0]                store_size,
  input logic                      halted,
  input logic [1:0]                status
);
  import rvx_pkg::*;

  logic            out_stall;
  logic [XLEN+1:0] held_fields;
  logic            faulted;
  logic            no_store;
  logic            store_fields_zero;
  logic            byte_store;
  logic            byte_data_masked;

  assign out_stall         = out_valid && !out_ready;
  assign held_fields       = {next_pc, status};
  assign faulted           = out_valid && (status != ST_OK);
  assign no_store          = out_valid && !store_request;
  assign store_fields_zero = (store_address == '0) && (store_data == '0) &&
                             (store_size == SZ_BYTE);
  assign byte_store        = out_valid && store_request && (store_size == SZ_BYTE);
  assign byte_data_masked  = (store_data[XLEN-1:8] == '0);

  `RVX_ASSERT_NXT(a_out_hold, out_stall, out_valid && $stable(held_fields), "stalled result changed")
  `RVX_ASSERT_NXT(a_halt_sticky, out_valid && halted, !out_valid || halted, "halted flag dropped")
  `RVX_ASSERT_IMP(a_no_store_on_fault, faulted, !store_request, "store on faulting request")
  `RVX_ASSERT_IMP(a_idle_store_zero, no_store, store_fields_zero, "stray store fields")
  `RVX_ASSERT_IMP(a_byte_mask, byte_store, byte_data_masked, "byte store data not masked")

endmodule

bind rv64_integer_subset_execute_unit rvx_checker u_rvx_checker (.*);

`default_nettype wire

FILE: test/rvx_execute_checker.sv
// Checker for the RV64 integer subset execute unit: predicts each result from the
// request channel and compares it with the result channel. Depends on rvx_pkg.
module rvx_execute_checker
  import rvx_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [ILEN-1:0]  instruction_word,
  input  logic [XLEN-1:0]  current_pc,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [XLEN-1:0]  next_pc,
  input  logic             store_request,
  input  logic [XLEN-1:0]  store_address,
  input  logic [XLEN-1:0]  store_data,
  input  logic [1:0]       store_size,
  input  logic             halted,
  input  logic [1:0]       status,
  output int               mismatches,
  output int               outstanding
);

  typedef struct packed {
    logic [ILEN-1:0] word;
    logic [XLEN-1:0] pc;
    logic [XLEN-1:0] next_pc;
    logic            store_request;
    logic [XLEN-1:0] store_address;
    logic [XLEN-1:0] store_data;
    logic [1:0]      store_size;
    logic            halted;
    logic [1:0]      status;
  } retire_t;

  logic [XLEN-1:0] gpr [NUM_REGS];
  logic            halt_seen;
  retire_t         predicted_q [$];
  int              mismatch_cnt = 0;

  function automatic void put_reg(input logic [4:0] idx, input logic [XLEN-1:0] val);
    if (idx != 5'd0) gpr[idx] = val;
  endfunction

  function automatic retire_t execute_instruction(input logic [ILEN-1:0] w,
                                                  input logic [XLEN-1:0] pc);
    logic [6:0]      opc;
    logic [4:0]      rd, rs1, rs2;
    logic [2:0]      f3;
    logic [XLEN-1:0] iimm, simm, jimm, val;
    retire_t         r;
    opc  = w[6:0];
    rd   = w[11:7];
    f3   = w[14:12];
    rs1  = w[19:15];
    rs2  = w[24:20];
    iimm = {{52{w[31]}}, w[31:20]};
    simm = {{52{w[31]}}, w[31:25], w[11:7]};
    jimm = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    r = '0;
    r.word    = w;
    r.pc      = pc;
    r.next_pc = pc + 64'd4;
    r.status  = ST_OK;
    case (opc)
      OPC_AUIPC: put_reg(rd, pc + {{32{w[31]}}, w[31:12], 12'h000});
      OPC_OPIMM: begin
        if (f3 == F3_ADDI) put_reg(rd, gpr[rs1] + iimm);
        else if (f3 == F3_ANDI) put_reg(rd, gpr[rs1] & iimm);
        else if (f3 == F3_SLLI && w[31:26] == 6'd0) put_reg(rd, gpr[rs1] << w[25:20]);
        else r.status = ST_ILLEGAL;
      end
      OPC_JAL: begin
        r.next_pc = pc + jimm;
        put_reg(rd, pc + 64'd4);
      end
      OPC_STORE: begin
        if (!f3[2]) begin
          val = gpr[rs2];
          case (f3[1:0])
            SZ_BYTE: val = {56'd0, val[7:0]};
            SZ_HALF: val = {48'd0, val[15:0]};
            SZ_WORD: val = {32'd0, val[31:0]};
            default: ;
          endcase
          r.store_request = 1'b1;
          r.store_address = gpr[rs1] + simm;
          r.store_data    = val;
          r.store_size    = f3[1:0];
        end else begin
          r.status = ST_ILLEGAL;
        end
      end
      OPC_SYSTEM: begin
        if (f3 == F3_WFI) halt_seen = 1'b1;
        else r.status = ST_UNIMPL;
      end
      default: r.status = ST_ILLEGAL;
    endcase
    r.halted = halt_seen;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    retire_t expd, got;
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) gpr[i] = '0;
      halt_seen = 1'b0;
      predicted_q.delete();
    end else begin
      if (in_valid && in_ready)
        predicted_q.push_back(execute_instruction(instruction_word, current_pc));
      if (out_valid && out_ready) begin
        got = '0;
        got.next_pc       = next_pc;
        got.store_request = store_request;
        got.store_address = store_address;
        got.store_data    = store_data;
        got.store_size    = store_size;
        got.halted        = halted;
        got.status        = status;
        if (predicted_q.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("unexpected result: next_pc %h status %0d", next_pc, status);
          mismatch_cnt++;
        end else begin
          expd = predicted_q.pop_front();
          got.word = expd.word;
          got.pc   = expd.pc;
          if (got !== expd) begin
            if (mismatch_cnt < 10) begin
              $display("mismatch for word %h at pc %h (expected / actual):", expd.word, expd.pc);
              $display("  next_pc %h / %h  status %0d / %0d  halted %b / %b",
                       expd.next_pc, got.next_pc, expd.status, got.status,
                       expd.halted, got.halted);
              $display("  store req %b / %b  size %0d / %0d",
                       expd.store_request, got.store_request, expd.store_size,
                       got.store_size);
              $display("  store addr %h / %h  data %h / %h",
                       expd.store_address, got.store_address, expd.store_data,
                       got.store_data);
            end
            mismatch_cnt++;
          end
        end
      end
    end
    mismatches  <= mismatch_cnt;
    outstanding <= predicted_q.size();
  end

endmodule

FILE: test/rv64_integer_subset_execute_unit_tb.sv
// Testbench top for the RV64 integer subset execute unit: drives directed and random
// instruction requests with random idling and gives the verdict. Uses rvx_pkg and
// rvx_execute_checker.
module rv64_integer_subset_execute_unit_tb;
  import rvx_pkg::*;

  localparam logic [6:0] OPC_OP    = 7'h33;
  localparam logic [2:0] F3_SLTI   = 3'd2;
  localparam logic [2:0] F3_ORI    = 3'd6;
  localparam logic [2:0] F3_CSRRW  = 3'd1;
  localparam logic [2:0] F3_CSRRCI = 3'd7;
  localparam int         RANDOM_ITEMS = 1950;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [ILEN-1:0] instruction_word = '0;
  logic [XLEN-1:0] current_pc = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [XLEN-1:0] next_pc;
  logic            store_request;
  logic [XLEN-1:0] store_address;
  logic [XLEN-1:0] store_data;
  logic [1:0]      store_size;
  logic            halted;
  logic [1:0]      status;
  int              fail_count;
  int              outstanding;
  bit              steady = 1'b0;
  int              hold_cnt = 0;

  always #6 clk = ~clk;

  rv64_integer_subset_execute_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .instruction_word(instruction_word), .current_pc(current_pc),
    .out_valid(out_valid), .out_ready(out_ready),
    .next_pc(next_pc), .store_request(store_request),
    .store_address(store_address), .store_data(store_data),
    .store_size(store_size), .halted(halted), .status(status)
  );

  rvx_execute_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .instruction_word(instruction_word), .current_pc(current_pc),
    .out_valid(out_valid), .out_ready(out_ready),
    .next_pc(next_pc), .store_request(store_request),
    .store_address(store_address), .store_data(store_data),
    .store_size(store_size), .halted(halted), .status(status),
    .mismatches(fail_count), .outstanding(outstanding)
  );

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (out_valid && out_ready) hold_cnt = steady ? 0 : $urandom_range(0, 3);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [31:0] enc_i(input logic [6:0] opc, input logic [4:0] rd,
                                        input logic [2:0] f3, input logic [4:0] rs1,
                                        input logic [11:0] imm);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(input logic [2:0] f3, input logic [4:0] rs1,
                                        input logic [4:0] rs2, input logic [11:0] imm);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
  endfunction

  function automatic logic [31:0] enc_u(input logic [4:0] rd, input logic [19:0] imm);
    return {imm, rd, OPC_AUIPC};
  endfunction

  function automatic logic [31:0] enc_j(input logic [4:0] rd, input logic [20:0] imm);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
  endfunction

  function automatic logic [XLEN-1:0] random_pc();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [31:0] random_instruction(input bit allow_wfi);
    logic [4:0]  rd, rs1, rs2;
    logic [11:0] imm;
    logic [19:0] upper;
    logic [20:0] joff;
    logic [1:0]  sz;
    logic [2:0]  f3;
    int          f6;
    int          pick;
    rd    = 5'($urandom_range(0, 31));
    rs1   = 5'($urandom_range(0, 31));
    rs2   = 5'($urandom_range(0, 31));
    imm   = 12'($urandom);
    upper = 20'($urandom);
    joff  = 21'($urandom);
    sz    = 2'($urandom);
    pick  = $urandom_range(0, 99);
    if (pick >= 80 && pick < 84 && !allow_wfi) pick = 20;
    if (pick < 14) return enc_u(rd, upper);
    if (pick < 34) return enc_i(OPC_OPIMM, rd, F3_ADDI, rs1, imm);
    if (pick < 44) return enc_i(OPC_OPIMM, rd, F3_ANDI, rs1, imm);
    if (pick < 54) return enc_i(OPC_OPIMM, rd, F3_SLLI, rs1, {6'd0, imm[5:0]});
    if (pick < 62) return enc_j(rd, joff);
    if (pick < 80) return enc_s({1'b0, sz}, rs1, rs2, imm);
    if (pick < 84) return enc_i(OPC_SYSTEM, rd, F3_WFI, rs1, imm);
    if (pick < 87) begin
      f3 = 3'($urandom_range(1, 7));
      return enc_i(OPC_SYSTEM, rd, f3, rs1, imm);
    end
    if (pick < 90) begin
      f3 = 3'($urandom_range(2, 6));
      return enc_i(OPC_OPIMM, rd, f3, rs1, imm);
    end
    if (pick < 92) begin
      f6 = $urandom_range(1, 63);
      return enc_i(OPC_OPIMM, rd, F3_SLLI, rs1, {f6[5:0], imm[5:0]});
    end
    if (pick < 94) return enc_s({1'b1, sz}, rs1, rs2, imm);
    return $urandom;
  endfunction

  task automatic send_request(input logic [31:0] w, input logic [XLEN-1:0] pc);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    instruction_word <= w;
    current_pc       <= pc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    #(12 * 300000);
    $display("FAIL rv64_integer_subset_execute_unit");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(enc_u(5'd1, 20'hfffff), '1);
    send_request(enc_u(5'd2, 20'h80000), '0);
    send_request(enc_u(5'd0, 20'h12345), random_pc());
    send_request(enc_i(OPC_OPIMM, 5'd3, F3_ADDI, 5'd1, 12'h800), random_pc());
    send_request(enc_i(OPC_OPIMM, 5'd4, F3_ADDI, 5'd0, 12'h7ff), random_pc());
    send_request(enc_i(OPC_OPIMM, 5'd0, F3_ADDI, 5'd1, 12'h005), random_pc());
    send_request(enc_i(OPC_OPIMM, 5'd5, F3_ANDI, 5'd2, 12'hfff), random_pc());
    send_request(enc_i(OPC_OPIMM, 5'd6, F3_ANDI, 5'd3, 12'h7ff), random_pc());
    send_request(enc_i(OPC_OPIMM, 5'd7, F3_SLLI, 5'd4, 12'h03f), random_pc());
    send_request(enc_i(OPC_OPIMM, 5'd8, F3_SLLI, 5'd2, 12'h000), random_pc());
    send_request(enc_i(OPC_OPIMM, 5'd9, F3_SLLI, 5'd4, 12'h401), random_pc());
    send_request(enc_i(OPC_OPIMM, 5'd9, F3_SLLI, 5'd4, 12'h801), random_pc());
    send_request(enc_i(OPC_OPIMM, 5'd9, F3_SLTI, 5'd1, 12'h123), random_pc());
    send_request(enc_i(OPC_OPIMM, 5'd9, F3_ORI, 5'd1, 12'hfff), random_pc());
    send_request(enc_j(5'd9, 21'h0ffffe), '1);
    send_request(enc_j(5'd0, 21'h100000), '0);
    send_request(enc_s({1'b0, SZ_BYTE}, 5'd1, 5'd2, 12'h800), random_pc());
    send_request(enc_s({1'b0, SZ_HALF}, 5'd0, 5'd1, 12'h7ff), random_pc());
    send_request(enc_s({1'b0, SZ_WORD}, 5'd3, 5'd9, 12'h000), random_pc());
    send_request(enc_s({1'b0, SZ_DOUBLE}, 5'd7, 5'd1, 12'hfff), random_pc());
    send_request(enc_s({1'b1, SZ_BYTE}, 5'd1, 5'd2, 12'h010), random_pc());
    send_request(enc_s({1'b1, SZ_DOUBLE}, 5'd1, 5'd2, 12'h010), random_pc());
    send_request(enc_i(OPC_SYSTEM, 5'd5, F3_CSRRW, 5'd1, 12'h300), random_pc());
    send_request(enc_i(OPC_SYSTEM, 5'd0, F3_CSRRCI, 5'd31, 12'hfff), random_pc());
    send_request(enc_i(OPC_OP, 5'd10, F3_ADDI, 5'd1, 12'h002), random_pc());
    send_request(32'hffffffff, random_pc());
    send_request(32'h00000000, random_pc());

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 128 == 0) steady = ($urandom_range(0, 4) == 0);
      if (i == RANDOM_ITEMS / 2) begin
        drain();
        send_request(enc_i(OPC_SYSTEM, 5'd0, F3_WFI, 5'd0, 12'h105), random_pc());
        send_request(random_instruction(1'b0), random_pc());
        send_request(enc_i(OPC_SYSTEM, 5'($urandom), F3_WFI, 5'($urandom), 12'($urandom)),
                     random_pc());
      end
      send_request(random_instruction(i > RANDOM_ITEMS / 2), random_pc());
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("PASS rv64_integer_subset_execute_unit");
    else
      $display("FAIL rv64_integer_subset_execute_unit");
    $finish;
  end

endmodule
